FILE: design/lppd_pkg.sv
// Package for the length-prefixed packet deframer.
// Byte classes, queue entry and result types; no dependencies.
package lppd_pkg;

  localparam int IDX_W = 4;

  localparam logic [IDX_W-1:0] IDX_TYPE_FIRST = 4'd0;
  localparam logic [IDX_W-1:0] IDX_TYPE_LAST  = 4'd1;
  localparam logic [IDX_W-1:0] IDX_MSG_FIRST  = 4'd2;
  localparam logic [IDX_W-1:0] IDX_MSG_LAST   = 4'd5;
  localparam logic [IDX_W-1:0] IDX_SESS_FIRST = 4'd6;
  localparam logic [IDX_W-1:0] IDX_SESS_LAST  = 4'd9;
  localparam logic [IDX_W-1:0] IDX_LEN_HI     = 4'd10;
  localparam logic [IDX_W-1:0] IDX_HDR_LAST   = 4'd11;

  typedef enum logic [2:0] {
    CLS_TYPE,
    CLS_MSG,
    CLS_SESS,
    CLS_LEN,
    CLS_HDR_END,
    CLS_BODY
  } byte_class_t;

  typedef enum logic {
    KIND_HEADER = 1'b0,
    KIND_BODY   = 1'b1
  } item_kind_t;

  typedef struct packed {
    byte_class_t cls;
    logic        last;
    logic [7:0]  data;
  } entry_t;

  typedef struct packed {
    item_kind_t  kind;
    logic [15:0] packet_type;
    logic [31:0] message_ident;
    logic [31:0] session_ident;
    logic [15:0] body_length;
    logic [7:0]  body_byte;
    logic        last;
  } result_t;

endpackage

FILE: design/lppd_fifo.sv
// Two-entry first-word-fall-through queue built from two registers.
// Generic width; no package dependency.
module lppd_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  logic [WIDTH-1:0] head;
  logic [WIDTH-1:0] spare;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign empty   = (count == 2'd0);
  assign full    = (count == 2'd2);
  assign dout    = head;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({do_push, do_pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({do_push, do_pop})
      2'b10: begin
        if (empty) begin
          head <= din;
        end else begin
          spare <= din;
        end
      end
      2'b01: head <= spare;
      2'b11: head <= din;
      default: head <= head;
    endcase
  end

endmodule

FILE: design/lppd_front.sv
// Front end: tracks header position and body count, tags each byte.
// Depends on lppd_pkg.
module lppd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      data_byte,
  output lppd_pkg::entry_t entry
);

  logic                        in_body;
  logic                        in_body_next;
  logic [lppd_pkg::IDX_W-1:0]  header_index;
  logic [lppd_pkg::IDX_W-1:0]  header_index_next;
  logic [7:0]                  length_hi;
  logic [15:0]                 remaining;
  logic [15:0]                 remaining_next;
  logic [15:0]                 length_word;

  assign length_word = {length_hi, data_byte};

  always_comb begin
    in_body_next      = in_body;
    header_index_next = header_index;
    remaining_next    = remaining;
    entry.data        = data_byte;
    entry.last        = 1'b0;
    entry.cls         = lppd_pkg::CLS_BODY;
    if (in_body) begin
      remaining_next = remaining - 16'd1;
      entry.last     = (remaining == 16'd1);
      if (remaining == 16'd1) begin
        in_body_next = 1'b0;
      end
    end else begin
      header_index_next = header_index + 4'd1;
      case (header_index) inside
        [lppd_pkg::IDX_TYPE_FIRST:lppd_pkg::IDX_TYPE_LAST]: entry.cls = lppd_pkg::CLS_TYPE;
        [lppd_pkg::IDX_MSG_FIRST:lppd_pkg::IDX_MSG_LAST]:   entry.cls = lppd_pkg::CLS_MSG;
        [lppd_pkg::IDX_SESS_FIRST:lppd_pkg::IDX_SESS_LAST]: entry.cls = lppd_pkg::CLS_SESS;
        lppd_pkg::IDX_LEN_HI:                               entry.cls = lppd_pkg::CLS_LEN;
        default: begin
          // final header byte, also taken for any stray index
          entry.cls         = lppd_pkg::CLS_HDR_END;
          entry.last        = (length_word == 16'd0);
          header_index_next = lppd_pkg::IDX_TYPE_FIRST;
          remaining_next    = length_word;
          in_body_next      = (length_word != 16'd0);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_body      <= 1'b0;
      header_index <= lppd_pkg::IDX_TYPE_FIRST;
      remaining    <= 16'd0;
    end else if (accept) begin
      in_body      <= in_body_next;
      header_index <= header_index_next;
      remaining    <= remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !in_body && header_index == lppd_pkg::IDX_LEN_HI) begin
      length_hi <= data_byte;
    end
  end

`ifndef ASSERT_OFF
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    header_index <= lppd_pkg::IDX_HDR_LAST)
    else $error("header index out of range");

  a_body_index_idle: assert property (@(posedge clk) disable iff (rst)
    in_body |-> header_index == lppd_pkg::IDX_TYPE_FIRST)
    else $error("header index moved during body");

  a_body_count_live: assert property (@(posedge clk) disable iff (rst)
    in_body |-> remaining != 16'd0)
    else $error("body phase with zero count");

  a_body_ends: assert property (@(posedge clk) disable iff (rst)
    (accept && in_body && remaining == 16'd1) |=> !in_body)
    else $error("body phase did not end on last byte");
`endif

endmodule

FILE: design/lppd_back.sv
// Back end: assembles header fields and builds result transactions.
// Depends on lppd_pkg.
module lppd_back (
  input  logic              clk,
  input  lppd_pkg::entry_t  entry,
  input  logic              entry_empty,
  output logic              entry_pop,
  input  logic              out_full,
  output logic              out_push,
  output lppd_pkg::result_t result
);

  logic [15:0] type_shift;
  logic [31:0] message_shift;
  logic [31:0] session_shift;
  logic [15:0] length_shift;
  logic [15:0] length_next;
  logic        makes_result;

  assign length_next  = {length_shift[7:0], entry.data};
  assign makes_result = (entry.cls == lppd_pkg::CLS_HDR_END) ||
                        (entry.cls == lppd_pkg::CLS_BODY);
  assign entry_pop    = !entry_empty && (!makes_result || !out_full);
  assign out_push     = !entry_empty && makes_result && !out_full;

  always_comb begin
    result.packet_type   = type_shift;
    result.message_ident = message_shift;
    result.session_ident = session_shift;
    result.last          = entry.last;
    if (entry.cls == lppd_pkg::CLS_BODY) begin
      result.kind        = lppd_pkg::KIND_BODY;
      result.body_length = length_shift;
      result.body_byte   = entry.data;
    end else begin
      result.kind        = lppd_pkg::KIND_HEADER;
      result.body_length = length_next;
      result.body_byte   = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (entry_pop) begin
      case (entry.cls)
        lppd_pkg::CLS_TYPE: type_shift    <= {type_shift[7:0], entry.data};
        lppd_pkg::CLS_MSG:  message_shift <= {message_shift[23:0], entry.data};
        lppd_pkg::CLS_SESS: session_shift <= {session_shift[23:0], entry.data};
        lppd_pkg::CLS_LEN, lppd_pkg::CLS_HDR_END: length_shift <= length_next;
        default: length_shift <= length_shift;
      endcase
    end
  end

endmodule

FILE: design/length_prefixed_packet_deframer.sv
// Length-prefixed packet deframer, top level. Depends on lppd_pkg and submodules.
// Throughput: one byte per cycle, sustained, while results are popped every cycle.
// Path: each accepted byte is tagged and written to the tag queue; the back end then moves
// its result, if any, into the result queue, which drives the result ports and is popped there.
// Reset: synchronous, active high; clears header position, body phase and both queues.
module length_prefixed_packet_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [7:0]  data_byte,
  output logic        full,
  input  logic        pop,
  output logic        empty,
  output logic        item_kind,
  output logic [15:0] packet_type,
  output logic [31:0] message_ident,
  output logic [31:0] session_ident,
  output logic [15:0] body_length,
  output logic [7:0]  body_byte,
  output logic        packet_last
);

  localparam int ENTRY_W  = $bits(lppd_pkg::entry_t);
  localparam int RESULT_W = $bits(lppd_pkg::result_t);

  lppd_pkg::entry_t  front_entry;
  lppd_pkg::entry_t  back_entry;
  lppd_pkg::result_t back_result;
  lppd_pkg::result_t head_result;
  logic              accept;
  logic              mid_empty;
  logic              mid_pop;
  logic              out_full;
  logic              out_push;
  logic [ENTRY_W-1:0]  mid_dout;
  logic [RESULT_W-1:0] out_dout;

  assign accept = push && !full;

  lppd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .entry     (front_entry)
  );

  lppd_fifo #(.WIDTH(ENTRY_W)) u_mid_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .din   (front_entry),
    .full  (full),
    .pop   (mid_pop),
    .dout  (mid_dout),
    .empty (mid_empty)
  );

  assign back_entry = lppd_pkg::entry_t'(mid_dout);

  lppd_back u_back (
    .clk         (clk),
    .entry       (back_entry),
    .entry_empty (mid_empty),
    .entry_pop   (mid_pop),
    .out_full    (out_full),
    .out_push    (out_push),
    .result      (back_result)
  );

  lppd_fifo #(.WIDTH(RESULT_W)) u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .din   (back_result),
    .full  (out_full),
    .pop   (pop),
    .dout  (out_dout),
    .empty (empty)
  );

  assign head_result   = lppd_pkg::result_t'(out_dout);
  assign item_kind     = head_result.kind;
  assign packet_type   = head_result.packet_type;
  assign message_ident = head_result.message_ident;
  assign session_ident = head_result.session_ident;
  assign body_length   = head_result.body_length;
  assign body_byte     = head_result.body_byte;
  assign packet_last   = head_result.last;

endmodule

FILE: tb/tb_length_prefixed_packet_deframer.sv
// Testbench for length_prefixed_packet_deframer: directed table, then random packets.
// Results are checked against the table's expected results or an in-bench deframing predictor; depends on lppd_pkg.
module tb_length_prefixed_packet_deframer;

  localparam int N_DIR      = 25;
  localparam int N_RAND     = 1780;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL       = 8;

  typedef struct packed {
    logic [7:0]        data;
    logic              chk;
    lppd_pkg::result_t res;
  } byte_item_t;

  typedef struct {
    bit          in_body;
    logic [3:0]  hdr_pos;
    logic [15:0] type_acc;
    logic [31:0] msg_acc;
    logic [31:0] sess_acc;
    logic [15:0] len_acc;
    logic [15:0] left;
  } deframer_state_t;

  localparam lppd_pkg::result_t R_NONE = '0;
  localparam lppd_pkg::result_t R_HDR_ONES =
    '{lppd_pkg::KIND_HEADER, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000, 8'h00, 1'b1};
  localparam lppd_pkg::result_t R_HDR_LEN1 =
    '{lppd_pkg::KIND_HEADER, 16'h0000, 32'h0, 32'h0, 16'h0001, 8'h00, 1'b0};
  localparam lppd_pkg::result_t R_BODY_FF =
    '{lppd_pkg::KIND_BODY, 16'h0000, 32'h0, 32'h0, 16'h0001, 8'hFF, 1'b1};

  // all-ones header with zero length, then all-zero header with one body byte
  byte_item_t dir_tab [N_DIR] = '{
    '{8'hFF, 1'b0, R_NONE}, '{8'hFF, 1'b0, R_NONE}, '{8'hFF, 1'b0, R_NONE},
    '{8'hFF, 1'b0, R_NONE}, '{8'hFF, 1'b0, R_NONE}, '{8'hFF, 1'b0, R_NONE},
    '{8'hFF, 1'b0, R_NONE}, '{8'hFF, 1'b0, R_NONE}, '{8'hFF, 1'b0, R_NONE},
    '{8'hFF, 1'b0, R_NONE}, '{8'h00, 1'b0, R_NONE}, '{8'h00, 1'b1, R_HDR_ONES},
    '{8'h00, 1'b0, R_NONE}, '{8'h00, 1'b0, R_NONE}, '{8'h00, 1'b0, R_NONE},
    '{8'h00, 1'b0, R_NONE}, '{8'h00, 1'b0, R_NONE}, '{8'h00, 1'b0, R_NONE},
    '{8'h00, 1'b0, R_NONE}, '{8'h00, 1'b0, R_NONE}, '{8'h00, 1'b0, R_NONE},
    '{8'h00, 1'b0, R_NONE}, '{8'h00, 1'b0, R_NONE}, '{8'h01, 1'b1, R_HDR_LEN1},
    '{8'hFF, 1'b1, R_BODY_FF}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        full;
  logic        pop = 1'b0;
  logic        empty;
  logic        item_kind;
  logic [15:0] packet_type;
  logic [31:0] message_ident;
  logic [31:0] session_ident;
  logic [15:0] body_length;
  logic [7:0]  body_byte;
  logic        packet_last;

  byte_item_t        byte_q [$];
  lppd_pkg::result_t frame_exp_q [$];
  deframer_state_t   dfm;
  int                err_cnt = 0;
  int                gap_left = 0;
  int                stall_left = 0;
  int                idle_cnt = 0;
  bit                tx_burst = 0;
  bit                rx_burst = 0;

  length_prefixed_packet_deframer DUT (
    .clk(clk), .rst(rst),
    .push(push), .data_byte(data_byte), .full(full),
    .pop(pop), .empty(empty),
    .item_kind(item_kind), .packet_type(packet_type),
    .message_ident(message_ident), .session_ident(session_ident),
    .body_length(body_length), .body_byte(body_byte), .packet_last(packet_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic deframe_byte(input logic [7:0] b, output bit got,
                              output lppd_pkg::result_t r);
    r = '0;
    got = 1'b0;
    if (dfm.in_body) begin
      dfm.left = dfm.left - 16'd1;
      r = '{lppd_pkg::KIND_BODY, dfm.type_acc, dfm.msg_acc, dfm.sess_acc, dfm.len_acc, b,
            dfm.left == 16'd0};
      if (dfm.left == 16'd0) dfm.in_body = 1'b0;
      got = 1'b1;
    end else begin
      if (dfm.hdr_pos <= lppd_pkg::IDX_TYPE_LAST) dfm.type_acc = {dfm.type_acc[7:0], b};
      else if (dfm.hdr_pos <= lppd_pkg::IDX_MSG_LAST) dfm.msg_acc = {dfm.msg_acc[23:0], b};
      else if (dfm.hdr_pos <= lppd_pkg::IDX_SESS_LAST)
        dfm.sess_acc = {dfm.sess_acc[23:0], b};
      else dfm.len_acc = {dfm.len_acc[7:0], b};
      if (dfm.hdr_pos < lppd_pkg::IDX_HDR_LAST) begin
        dfm.hdr_pos = dfm.hdr_pos + 4'd1;
      end else begin
        // final header byte, also taken for a stray position
        dfm.hdr_pos = '0;
        r = '{lppd_pkg::KIND_HEADER, dfm.type_acc, dfm.msg_acc, dfm.sess_acc, dfm.len_acc,
              8'h00, dfm.len_acc == 16'd0};
        if (dfm.len_acc != 16'd0) begin
          dfm.in_body = 1'b1;
          dfm.left = dfm.len_acc;
        end
        got = 1'b1;
      end
    end
  endtask

  task automatic queue_byte(input logic [7:0] b);
    byte_item_t it;
    it = '{b, 1'b0, R_NONE};
    byte_q.push_back(it);
  endtask

  task automatic queue_packet(input logic [15:0] len);
    logic [95:0] hdr;
    int r;
    r = $urandom_range(0, 9);
    hdr[95:80] = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
    hdr[79:48] = $urandom;
    hdr[47:16] = $urandom;
    if (r == 2) hdr[79:16] = '1;
    if (r == 3) hdr[79:16] = '0;
    hdr[15:0] = len;
    for (int i = 0; i < 12; i++) queue_byte(hdr[95 - 8*i -: 8]);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 19);
      queue_byte(r == 0 ? 8'h00 : r == 1 ? 8'hFF : 8'($urandom));
    end
  endtask

  // sender: byte held until taken
  always @(posedge clk) begin
    bit                got;
    lppd_pkg::result_t r;
    if (rst) begin
      push <= 1'b0;
      dfm = '{default: '0};
    end else begin
      if (push && !full) begin
        deframe_byte(byte_q[0].data, got, r);
        if (byte_q[0].chk) frame_exp_q.push_back(byte_q[0].res);
        else if (got) frame_exp_q.push_back(r);
        void'(byte_q.pop_front());
        if ($urandom_range(0, 149) == 0) tx_burst = !tx_burst;
        gap_left = tx_burst ? 0 : idle_len();
      end
      if (!(push && full)) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (byte_q.size() > 0) begin
          push <= 1'b1;
          data_byte <= byte_q[0].data;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // receiver: compare each popped transaction with the oldest expectation
  always @(posedge clk) begin
    lppd_pkg::result_t seen;
    lppd_pkg::result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        seen = '{lppd_pkg::item_kind_t'(item_kind), packet_type, message_ident,
                 session_ident, body_length, body_byte, packet_last};
        if (frame_exp_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected result: kind=%0d type=%h msg=%h sess=%h len=%h byte=%h last=%0d",
                     seen.kind, seen.packet_type, seen.message_ident, seen.session_ident,
                     seen.body_length, seen.body_byte, seen.last);
        end else begin
          want = frame_exp_q.pop_front();
          if (seen.kind !== want.kind || seen.packet_type !== want.packet_type ||
              seen.message_ident !== want.message_ident ||
              seen.session_ident !== want.session_ident ||
              seen.body_length !== want.body_length || seen.body_byte !== want.body_byte ||
              seen.last !== want.last) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("mismatch exp: kind=%0d type=%h msg=%h sess=%h len=%h byte=%h last=%0d",
                       want.kind, want.packet_type, want.message_ident, want.session_ident,
                       want.body_length, want.body_byte, want.last);
              $display("         got: kind=%0d type=%h msg=%h sess=%h len=%h byte=%h last=%0d",
                       seen.kind, seen.packet_type, seen.message_ident, seen.session_ident,
                       seen.body_length, seen.body_byte, seen.last);
            end
          end
        end
        if ($urandom_range(0, 149) == 0) rx_burst = !rx_burst;
        stall_left = rx_burst ? 0 : idle_len();
      end else if (stall_left > 0) begin
        stall_left--;
      end
      pop <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    int r;
    int n_keep;
    for (int i = 0; i < N_DIR; i++) byte_q.push_back(dir_tab[i]);
    while (byte_q.size() < N_DIR + N_RAND) begin
      r = $urandom_range(0, 99);
      if (r < 15) queue_packet(16'd0);
      else if (r < 80) queue_packet(16'($urandom_range(1, 16)));
      else if (r < 95) queue_packet(16'($urandom_range(17, 64)));
      else queue_packet(16'($urandom_range(65, 300)));
    end
    // header at the largest length; the run stops part-way into its body
    n_keep = byte_q.size() + 12 + 40;
    queue_packet(16'hFFFF);
    while (byte_q.size() > n_keep) void'(byte_q.pop_back());

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (byte_q.size() != 0 || push) @(negedge clk);
    while (frame_exp_q.size() != 0) @(negedge clk);
    repeat (TAIL) @(negedge clk);

    if (err_cnt == 0 && frame_exp_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
